### src/bmpd_pkg.sv
package bmpd_pkg;

    localparam int unsigned HEADER_BYTES = 54;
    localparam logic [31:0] POS_MARK_B   = 32'd0;
    localparam logic [31:0] POS_MARK_M   = 32'd1;
    localparam logic [31:0] POS_OFS_LO   = 32'd10;
    localparam logic [31:0] POS_OFS_HI   = 32'd11;
    localparam logic [31:0] POS_WID_LO   = 32'd18;
    localparam logic [31:0] POS_WID_HI   = 32'd19;
    localparam logic [31:0] POS_HGT_0    = 32'd22;
    localparam logic [31:0] POS_HGT_1    = 32'd23;
    localparam logic [31:0] POS_HGT_2    = 32'd24;
    localparam logic [31:0] POS_HGT_3    = 32'd25;
    localparam logic [31:0] POS_DEPTH    = 32'd28;
    localparam logic [31:0] POS_HDR_LAST = 32'(HEADER_BYTES - 1);
    localparam logic [31:0] POS_HDR_END  = 32'(HEADER_BYTES);
    localparam logic [31:0] POS_MAX      = 32'hFFFF_FFFF;

    localparam logic [7:0] MARK_B     = 8'h42;
    localparam logic [7:0] MARK_M     = 8'h4D;
    localparam logic [7:0] DEPTH_RGB  = 8'd24;
    localparam logic [7:0] DEPTH_RGBA = 8'd32;
    localparam logic [7:0] OPAQUE     = 8'hFF;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_SHORT      = 3'd1,
        ST_NOT_BM     = 3'd2,
        ST_BAD_DEPTH  = 3'd3,
        ST_LOW_OFFSET = 3'd4,
        ST_TRUNCATED  = 3'd5
    } t_status;

    typedef struct packed {
        logic        pix_v;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic        st_v;
        t_status     status;
        logic [15:0] width;
        logic [31:0] raw_height;
    } t_entry;

endpackage

### src/bmp_pixel_stream_decoder.sv
// An item is queued when its last byte is taken and then moves to the output register.
// Throughput: one byte per cycle while the queue is not full, set by the front's header
// and line counters; a final byte that also completes a pixel yields two items, pixel first.
// A four-entry queue between front and back absorbs output stalls.
// Reset is synchronous, active low, and clears all counters and the queue; the
// header and line state also return to reset after each end-of-file byte.
module bmp_pixel_stream_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_file,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_kind,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    output logic [7:0]  o_alpha,
    output logic [2:0]  o_status,
    output logic [15:0] o_image_width,
    output logic [31:0] o_image_height,
    output logic        o_last
);
    import bmpd_pkg::*;

    logic   push;
    logic   pop;
    logic   full;
    logic   q_valid;
    t_entry push_entry;
    t_entry head_entry;

    assign o_in_stall = full;

    bmpd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_data_byte   (i_data_byte),
        .i_end_of_file (i_end_of_file),
        .i_full        (full),
        .o_push        (push),
        .o_entry       (push_entry)
    );

    bmpd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_full  (full),
        .o_valid (q_valid),
        .o_entry (head_entry)
    );

    bmpd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_q_entry      (head_entry),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_kind         (o_kind),
        .o_red          (o_red),
        .o_green        (o_green),
        .o_blue         (o_blue),
        .o_alpha        (o_alpha),
        .o_status       (o_status),
        .o_image_width  (o_image_width),
        .o_image_height (o_image_height),
        .o_last         (o_last)
    );

endmodule

### src/bmpd_front.sv
module bmpd_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [7:0]       i_data_byte,
    input  logic             i_end_of_file,
    input  logic             i_full,
    output logic             o_push,
    output bmpd_pkg::t_entry o_entry
);
    import bmpd_pkg::*;

    logic [31:0] r_byte_pos,   n_byte_pos;
    logic [15:0] r_pixel_start, n_pixel_start;
    logic [15:0] r_width,      n_width;
    logic [31:0] r_raw_height, n_raw_height;
    logic [31:0] r_abs_height;
    logic [7:0]  r_depth,      n_depth;
    logic        r_marker_good, n_marker_good;
    logic [17:0] r_padded,     n_padded;
    logic [17:0] r_line_bytes, n_line_bytes;
    logic [7:0]  r_chan_buf [3];
    logic [7:0]  n_chan_buf [3];
    logic [1:0]  r_chan_idx,   n_chan_idx;
    logic [17:0] r_byte_in_line, n_byte_in_line;
    logic [31:0] r_row_count,  n_row_count;

    logic        accept;
    logic        is_rgba;
    logic        pix_phase;
    logic        in_data;
    logic        chan_last;
    logic [17:0] bil_inc;
    logic [17:0] raw_line;
    t_status     hdr_code;
    t_status     status;

    assign accept  = i_in_valid && !i_full;
    assign is_rgba = (r_depth == DEPTH_RGBA);
    assign bil_inc = r_byte_in_line + 18'd1;
    assign in_data = (r_byte_in_line < r_line_bytes);
    assign chan_last = is_rgba ? (r_chan_idx == 2'd3) : (r_chan_idx >= 2'd2);
    assign raw_line = is_rgba ? {r_width, 2'b00}
                              : ({1'b0, r_width, 1'b0} + {2'b00, r_width});

    always_comb begin
        if (!r_marker_good) begin
            hdr_code = ST_NOT_BM;
        end else if (r_depth != DEPTH_RGB && r_depth != DEPTH_RGBA) begin
            hdr_code = ST_BAD_DEPTH;
        end else if ({16'b0, r_pixel_start} < POS_HDR_END) begin
            hdr_code = ST_LOW_OFFSET;
        end else begin
            hdr_code = ST_OK;
        end
    end

    assign pix_phase = (r_byte_pos >= POS_HDR_END) && (hdr_code == ST_OK)
                    && (r_byte_pos >= {16'b0, r_pixel_start}) && (r_padded != 18'd0)
                    && (r_row_count < r_abs_height);

    always_comb begin
        n_byte_pos     = (r_byte_pos == POS_MAX) ? r_byte_pos : r_byte_pos + 32'd1;
        n_pixel_start  = r_pixel_start;
        n_width        = r_width;
        n_raw_height   = r_raw_height;
        n_depth        = r_depth;
        n_marker_good  = r_marker_good;
        n_padded       = r_padded;
        n_line_bytes   = r_line_bytes;
        n_chan_buf     = r_chan_buf;
        n_chan_idx     = r_chan_idx;
        n_byte_in_line = r_byte_in_line;
        n_row_count    = r_row_count;

        if (r_byte_pos < POS_HDR_END) begin
            if (r_byte_pos == POS_MARK_B && i_data_byte != MARK_B) n_marker_good = 1'b0;
            if (r_byte_pos == POS_MARK_M && i_data_byte != MARK_M) n_marker_good = 1'b0;
            if (r_byte_pos == POS_OFS_LO) n_pixel_start[7:0]  = i_data_byte;
            if (r_byte_pos == POS_OFS_HI) n_pixel_start[15:8] = i_data_byte;
            if (r_byte_pos == POS_WID_LO) n_width[7:0]        = i_data_byte;
            if (r_byte_pos == POS_WID_HI) n_width[15:8]       = i_data_byte;
            if (r_byte_pos == POS_HGT_0)  n_raw_height[7:0]   = i_data_byte;
            if (r_byte_pos == POS_HGT_1)  n_raw_height[15:8]  = i_data_byte;
            if (r_byte_pos == POS_HGT_2)  n_raw_height[23:16] = i_data_byte;
            if (r_byte_pos == POS_HGT_3)  n_raw_height[31:24] = i_data_byte;
            if (r_byte_pos == POS_DEPTH)  n_depth             = i_data_byte;
            if (r_byte_pos == POS_HDR_LAST) begin
                // round the line length up to a whole word
                n_line_bytes = raw_line;
                n_padded     = (raw_line + 18'd3) & 18'h3FFFC;
            end
        end else if (pix_phase) begin
            if (in_data) begin
                if (chan_last) begin
                    n_chan_idx = 2'd0;
                end else begin
                    if (r_chan_idx != 2'd3) n_chan_buf[r_chan_idx] = i_data_byte;
                    n_chan_idx = r_chan_idx + 2'd1;
                end
            end
            n_byte_in_line = bil_inc;
            if (bil_inc >= r_padded) begin
                n_byte_in_line = 18'd0;
                n_chan_idx     = 2'd0;
                n_row_count    = r_row_count + 32'd1;
            end
        end
    end

    always_comb begin
        if (r_byte_pos < POS_HDR_LAST) begin
            status = ST_SHORT;
        end else if (hdr_code == ST_OK && n_padded != 18'd0 && n_row_count < r_abs_height) begin
            status = ST_TRUNCATED;
        end else begin
            status = hdr_code;
        end
    end

    always_comb begin
        o_entry.pix_v      = accept && pix_phase && in_data && chan_last;
        o_entry.red        = is_rgba ? r_chan_buf[2] : i_data_byte;
        o_entry.green      = r_chan_buf[1];
        o_entry.blue       = r_chan_buf[0];
        o_entry.alpha      = is_rgba ? i_data_byte : OPAQUE;
        o_entry.st_v       = accept && i_end_of_file;
        o_entry.status     = status;
        o_entry.width      = n_width;
        o_entry.raw_height = n_raw_height;
    end

    assign o_push = o_entry.pix_v || o_entry.st_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_abs_height <= 32'd0;
        end else begin
            r_abs_height <= r_raw_height[31] ? (32'd0 - r_raw_height) : r_raw_height;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (accept && i_end_of_file)) begin
            r_byte_pos     <= 32'd0;
            r_pixel_start  <= 16'd0;
            r_width        <= 16'd0;
            r_raw_height   <= 32'd0;
            r_depth        <= 8'd0;
            r_marker_good  <= 1'b1;
            r_padded       <= 18'd0;
            r_line_bytes   <= 18'd0;
            r_chan_buf     <= '{8'd0, 8'd0, 8'd0};
            r_chan_idx     <= 2'd0;
            r_byte_in_line <= 18'd0;
            r_row_count    <= 32'd0;
        end else if (accept) begin
            r_byte_pos     <= n_byte_pos;
            r_pixel_start  <= n_pixel_start;
            r_width        <= n_width;
            r_raw_height   <= n_raw_height;
            r_depth        <= n_depth;
            r_marker_good  <= n_marker_good;
            r_padded       <= n_padded;
            r_line_bytes   <= n_line_bytes;
            r_chan_buf     <= n_chan_buf;
            r_chan_idx     <= n_chan_idx;
            r_byte_in_line <= n_byte_in_line;
            r_row_count    <= n_row_count;
        end
    end

endmodule

### src/bmpd_queue.sv
module bmpd_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  bmpd_pkg::t_entry i_entry,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_valid,
    output bmpd_pkg::t_entry o_entry
);
    import bmpd_pkg::*;

    t_entry              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QPTR_W:0]     r_count;

    assign o_full  = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_entry;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (i_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

### src/bmpd_back.sv
module bmpd_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  bmpd_pkg::t_entry i_q_entry,
    output logic             o_pop,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic             o_kind,
    output logic [7:0]       o_red,
    output logic [7:0]       o_green,
    output logic [7:0]       o_blue,
    output logic [7:0]       o_alpha,
    output logic [2:0]       o_status,
    output logic [15:0]      o_image_width,
    output logic [31:0]      o_image_height,
    output logic             o_last
);
    import bmpd_pkg::*;

    logic        r_out_valid;
    logic        r_pix_sent;
    logic        r_kind;
    logic [7:0]  r_red, r_green, r_blue, r_alpha;
    t_status     r_status;
    logic [15:0] r_width;
    logic [31:0] r_height;

    logic        out_free;
    logic        load;
    logic        use_pix;
    logic [31:0] abs_height;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign load       = out_free && i_q_valid;
    assign use_pix    = i_q_entry.pix_v && !r_pix_sent;
    // an entry with a pixel and a status stays at the head until its status is loaded too
    assign o_pop      = load && !(use_pix && i_q_entry.st_v);
    assign abs_height = i_q_entry.raw_height[31] ? (32'd0 - i_q_entry.raw_height)
                                                 : i_q_entry.raw_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_pix_sent  <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= i_q_valid;
            if (load) r_pix_sent <= use_pix && i_q_entry.st_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            if (use_pix) begin
                r_kind   <= 1'b0;
                r_red    <= i_q_entry.red;
                r_green  <= i_q_entry.green;
                r_blue   <= i_q_entry.blue;
                r_alpha  <= i_q_entry.alpha;
                r_status <= ST_OK;
                r_width  <= 16'd0;
                r_height <= 32'd0;
            end else begin
                r_kind   <= 1'b1;
                r_red    <= 8'd0;
                r_green  <= 8'd0;
                r_blue   <= 8'd0;
                r_alpha  <= 8'd0;
                r_status <= i_q_entry.status;
                r_width  <= i_q_entry.width;
                r_height <= abs_height;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_kind         = r_kind;
    assign o_red          = r_red;
    assign o_green        = r_green;
    assign o_blue         = r_blue;
    assign o_alpha        = r_alpha;
    assign o_status       = r_status;
    assign o_image_width  = r_width;
    assign o_image_height = r_height;
    assign o_last         = r_kind;

endmodule
